// File: hdl/apf_pkg.sv
// Shared constants, widths and the state type of the first-order allpass filter unit.
package apf_pkg;

    localparam int APF_SAMPLE_WIDTH    = 16;
    localparam int APF_COEF_FRAC_BITS  = 16;
    localparam int APF_RATE_W          = 18;
    localparam int APF_FREQ_W          = 16;
    localparam int APF_PI_W            = 18;
    localparam int APF_RATE_FRAC       = 16;
    localparam int APF_RQ_W            = APF_RATE_W + APF_RATE_FRAC;
    localparam int APF_PF_W            = APF_PI_W + APF_FREQ_W;
    localparam int APF_MAG_W           = APF_RQ_W;
    localparam int APF_DEN_W           = APF_RQ_W + 1;
    localparam int APF_QUEUE_DEPTH     = 2;

    localparam logic [APF_PI_W-1:0]   APF_PI_Q16     = 18'd205887;
    localparam logic [APF_RATE_W-1:0] APF_RATE_RESET = 18'd48000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROUND,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } t_back_state;

endpackage

// File: hdl/apf_queue.sv
// Small register queue that decouples the front part from the back part.
module apf_queue
    import apf_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = APF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hdl/apf_front.sv
// Front part: accepts a request, forms the coefficient numerator and denominator.
module apf_front
    import apf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = APF_SAMPLE_WIDTH,
    parameter int ENTRY_W      = SAMPLE_WIDTH + APF_MAG_W + APF_DEN_W + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [APF_RATE_W-1:0]   i_rate,
    input  logic                    i_push,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [APF_FREQ_W-1:0]   i_freq,
    output logic                    o_full,
    output logic                    o_q_push,
    output logic [ENTRY_W-1:0]      o_q_data,
    input  logic                    i_q_full
);

    logic                    r_valid;
    logic [SAMPLE_WIDTH-1:0] r_x;
    logic [APF_RQ_W-1:0]     r_rq;
    logic [APF_PF_W-1:0]     r_pf;
    logic [APF_DEN_W-1:0]    w_den;
    logic [APF_MAG_W-1:0]    w_mag;
    logic                    w_neg;
    logic                    w_zden;
    logic                    w_accept;

    assign o_q_push = r_valid && !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;

    assign w_den  = APF_DEN_W'(r_rq) + APF_DEN_W'(r_pf);
    assign w_neg  = (r_rq >= r_pf);
    assign w_mag  = w_neg ? (r_rq - r_pf) : (r_pf - r_rq);
    assign w_zden = (w_den == '0);

    assign o_q_data = {r_x, w_mag, w_den, w_neg, w_zden};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x  <= i_sample;
            r_rq <= {i_rate, {APF_RATE_FRAC{1'b0}}};
            r_pf <= APF_PF_W'(APF_PI_Q16) * APF_PF_W'(i_freq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: hdl/apf_back.sv
// Back part: iterative coefficient divider, filter arithmetic and result register.
module apf_back
    import apf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = APF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = APF_COEF_FRAC_BITS,
    parameter int ENTRY_W        = SAMPLE_WIDTH + APF_MAG_W + APF_DEN_W + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    input  logic [ENTRY_W-1:0]      i_q_data,
    output logic                    o_q_pop,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic [SAMPLE_WIDTH-1:0] o_sample
);

    localparam int Q_W    = COEF_FRAC_BITS + 1;
    localparam int A0_W   = COEF_FRAC_BITS + 2;
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int ACC_W  = COEF_FRAC_BITS + SAMPLE_WIDTH + 3;
    localparam int CNT_W  = $clog2(COEF_FRAC_BITS + 1);

    localparam logic signed [A0_W-1:0]  A0_NEG_ONE = -$signed(A0_W'(1) << COEF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_HALF   = $signed(ACC_W'(1) << (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] Y_HI =
        $signed((ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1));
    localparam logic signed [ACC_W-1:0] Y_LO = -Y_HI - ACC_W'(1);

    t_back_state r_state;
    t_back_state n_state;

    logic [SAMPLE_WIDTH-1:0]        w_e_x;
    logic [APF_MAG_W-1:0]           w_e_mag;
    logic [APF_DEN_W-1:0]           w_e_den;
    logic                           w_e_neg;
    logic                           w_e_zden;

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [APF_DEN_W-1:0]           r_den;
    logic [APF_DEN_W-1:0]           r_rem;
    logic [Q_W-1:0]                 r_q;
    logic                           r_neg;
    logic                           r_zden;
    logic [CNT_W-1:0]               r_cnt;
    logic signed [A0_W-1:0]         r_a0;
    logic signed [DIFF_W-1:0]       r_diff;
    logic signed [ACC_W-1:0]        r_prod;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic signed [SAMPLE_WIDTH-1:0] r_prev_in;
    logic signed [SAMPLE_WIDTH-1:0] r_prev_out;
    logic                           r_out_valid;
    logic [SAMPLE_WIDTH-1:0]        r_out;

    logic [APF_DEN_W:0]             w_trial;
    logic                           w_ge;
    logic [Q_W-1:0]                 w_q_rnd;
    logic signed [A0_W-1:0]         w_q_s;
    logic signed [ACC_W-1:0]        w_acc;
    logic signed [ACC_W-1:0]        w_yfull;
    logic signed [SAMPLE_WIDTH-1:0] w_ysat;
    logic                           w_out_free;
    logic                           w_commit;

    assign {w_e_x, w_e_mag, w_e_den, w_e_neg, w_e_zden} = i_q_data;

    assign w_trial  = {r_rem, 1'b0};
    assign w_ge     = (w_trial >= (APF_DEN_W + 1)'(r_den));
    assign w_q_rnd  = w_ge ? r_q + 1'b1 : r_q;
    assign w_q_s    = $signed({1'b0, w_q_rnd});

    assign w_acc    = r_prod + (ACC_W'(r_prev_in) <<< COEF_FRAC_BITS) + ACC_HALF;
    assign w_yfull  = w_acc >>> COEF_FRAC_BITS;
    assign w_ysat   = (w_yfull > Y_HI) ? SAMPLE_WIDTH'(Y_HI) :
                      (w_yfull < Y_LO) ? SAMPLE_WIDTH'(Y_LO) : SAMPLE_WIDTH'(w_yfull);

    assign w_out_free = !r_out_valid || i_pop;
    assign o_empty    = !r_out_valid;
    assign o_sample   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: n_state = ST_MUL;
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x    <= $signed(w_e_x);
                r_den  <= w_e_den;
                r_neg  <= w_e_neg;
                r_zden <= w_e_zden;
                r_cnt  <= CNT_W'(COEF_FRAC_BITS);
                if (APF_DEN_W'(w_e_mag) >= w_e_den) begin
                    r_rem <= APF_DEN_W'(w_e_mag) - w_e_den;
                    r_q   <= Q_W'(1);
                end else begin
                    r_rem <= APF_DEN_W'(w_e_mag);
                    r_q   <= '0;
                end
            end
            ST_DIV: begin
                r_cnt <= r_cnt - 1'b1;
                r_q   <= {r_q[Q_W-2:0], w_ge};
                if (w_ge) begin
                    r_rem <= APF_DEN_W'(w_trial - (APF_DEN_W + 1)'(r_den));
                end else begin
                    r_rem <= APF_DEN_W'(w_trial);
                end
            end
            ST_ROUND: begin
                if (r_zden) begin
                    r_a0 <= A0_NEG_ONE;
                end else if (r_neg) begin
                    r_a0 <= -w_q_s;
                end else begin
                    r_a0 <= w_q_s;
                end
                r_diff <= DIFF_W'(r_x) - DIFF_W'(r_prev_out);
            end
            ST_MUL: begin
                r_prod <= r_a0 * r_diff;
            end
            ST_ACC: begin
                r_y <= w_ysat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_in   <= '0;
            r_prev_out  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_prev_in   <= r_x;
                r_prev_out  <= r_y;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= r_y;
        end
    end

endmodule

// File: hdl/first_order_allpass_filter_unit.sv
// Top level of the first-order allpass filter unit with its sample rate register.
// Each request carries one signed sample and a break frequency in hertz and yields one
// filtered, rounded and saturated sample, y = a0*(x - previous y) + previous x, with
// a0 = -(R - pi*f)/(R + pi*f) formed per request. The front part registers each request
// and can take the next as it hands one on through a two-entry queue to the back part,
// where a restoring divider producing one quotient bit per cycle sets the rate; the back
// part pops the next request only after the last one has left its output state.
// Results wait in an output register, so the front keeps accepting requests until the
// queue fills. The sample rate register resets to 48000 and should be written only
// while no request is in flight; writes are always taken.
module first_order_allpass_filter_unit
    import apf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = APF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = APF_COEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [APF_RATE_W-1:0]   i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic [APF_FREQ_W-1:0]   i_cutoff_hz,
    output logic                    empty,
    input  logic                    pop,
    output logic [SAMPLE_WIDTH-1:0] o_sample_out
);

    localparam int ENTRY_W = SAMPLE_WIDTH + APF_MAG_W + APF_DEN_W + 2;

    logic [APF_RATE_W-1:0] r_sample_rate;
    logic                  w_q_push;
    logic                  w_q_full;
    logic                  w_q_pop;
    logic                  w_q_empty;
    logic [ENTRY_W-1:0]    w_q_wdata;
    logic [ENTRY_W-1:0]    w_q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= APF_RATE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sample_rate <= i_cfg_data;
        end
    end

    apf_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rate   (r_sample_rate),
        .i_push   (push),
        .i_sample (i_sample_in),
        .i_freq   (i_cutoff_hz),
        .o_full   (full),
        .o_q_push (w_q_push),
        .o_q_data (w_q_wdata),
        .i_q_full (w_q_full)
    );

    apf_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (APF_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    apf_back #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .ENTRY_W        (ENTRY_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_sample  (o_sample_out)
    );

endmodule

// File: sim/first_order_allpass_filter_unit_tb.sv
// Self-checking testbench of the first-order allpass filter unit.
module first_order_allpass_filter_unit_tb
    import apf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [APF_RATE_W-1:0]        i_cfg_data = '0;
    logic                         push = 1'b0;
    logic                         full;
    logic [APF_SAMPLE_WIDTH-1:0]  i_sample_in = '0;
    logic [APF_FREQ_W-1:0]        i_cutoff_hz = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic [APF_SAMPLE_WIDTH-1:0]  o_sample_out;

    // Predictor state, kept in step with the requests the unit accepts.
    logic [APF_RATE_W-1:0]              rate_hz = APF_RATE_RESET;
    logic signed [APF_SAMPLE_WIDTH-1:0] last_x = '0;
    logic signed [APF_SAMPLE_WIDTH-1:0] last_y = '0;
    logic [APF_SAMPLE_WIDTH-1:0]        expected_samples[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int samples_sent = 0;
    int samples_checked = 0;
    int rate_writes = 0;
    int cycle_count = 0;

    first_order_allpass_filter_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_sample_in  (i_sample_in),
        .i_cutoff_hz  (i_cutoff_hz),
        .empty        (empty),
        .pop          (pop),
        .o_sample_out (o_sample_out)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, expected_samples.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [APF_SAMPLE_WIDTH-1:0] allpass_next_sample(
        input logic signed [APF_SAMPLE_WIDTH-1:0] x,
        input logic [APF_FREQ_W-1:0]              f
    );
        longint unsigned rate_q, pi_f, den, mag, quo, rem;
        longint          coef_q, acc, y;
        bit              neg;
        rate_q = longint'(rate_hz) << APF_RATE_FRAC;
        pi_f   = longint'(APF_PI_Q16) * longint'(f);
        den    = rate_q + pi_f;
        if (den == 0) begin
            coef_q = -(longint'(1) << APF_COEF_FRAC_BITS);
        end else begin
            neg = (rate_q >= pi_f);
            mag = neg ? rate_q - pi_f : pi_f - rate_q;
            quo = (mag << APF_COEF_FRAC_BITS) / den;
            rem = (mag << APF_COEF_FRAC_BITS) % den;
            if (2 * rem >= den) begin
                quo++;
            end
            coef_q = neg ? -longint'(quo) : longint'(quo);
        end
        acc = coef_q * (longint'(x) - longint'(last_y))
            + (longint'(last_x) <<< APF_COEF_FRAC_BITS);
        y = (acc + (longint'(1) <<< (APF_COEF_FRAC_BITS - 1))) >>> APF_COEF_FRAC_BITS;
        if (y > 32767) begin
            y = 32767;
        end
        if (y < -32768) begin
            y = -32768;
        end
        last_x = x;
        last_y = y[APF_SAMPLE_WIDTH-1:0];
        return y[APF_SAMPLE_WIDTH-1:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what,
                     $signed(exp_v), $signed(act_v));
        end
    endtask

    always @(negedge i_clk) begin
        pop <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            samples_checked++;
            if (expected_samples.size() == 0) begin
                note_mismatch("unexpected sample_out", '0, o_sample_out);
            end else if (o_sample_out !== expected_samples[0]) begin
                note_mismatch("sample_out", expected_samples[0], o_sample_out);
                void'(expected_samples.pop_front());
            end else begin
                void'(expected_samples.pop_front());
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] x, input logic [15:0] f);
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_sample_in <= x;
        i_cutoff_hz <= f;
        do begin
            @(posedge i_clk);
        end while (full);
        expected_samples.push_back(allpass_next_sample(x, f));
        samples_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [APF_RATE_W-1:0] rate);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rate;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        rate_hz = rate;
        rate_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_cutoff();
        int unsigned nyq;
        nyq = (rate_hz / 2 > 65535) ? 65535 : rate_hz / 2;
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'($urandom);
            2: return 16'(nyq);
            default: return 16'($urandom_range(nyq));
        endcase
    endfunction

    task automatic test_reset_rate_extremes();
        send_sample(16'sd0, 16'd0);
        send_sample(16'sh7fff, 16'd0);
        send_sample(-16'sh8000, 16'd0);
        send_sample(16'sh7fff, 16'd0);
        send_sample(16'sh7fff, 16'd65535);
        send_sample(-16'sh8000, 16'd65535);
        send_sample(16'sd12000, 16'd24000);
        send_sample(-16'sd5000, 16'd30000);
        send_sample(16'sd1, 16'd1);
        send_sample(-16'sd1, 16'd1000);
        stop_sending();
    endtask

    task automatic test_odd_rates();
        write_rate(18'd0);
        send_sample(16'sd20000, 16'd0);
        send_sample(-16'sd20000, 16'd0);
        send_sample(16'sd3000, 16'd440);
        send_sample(16'sh7fff, 16'd65535);
        stop_sending();
        write_rate(18'd1);
        send_sample(-16'sh8000, 16'd0);
        send_sample(16'sd100, 16'd1);
        stop_sending();
        write_rate(18'h3ffff);
        send_sample(16'sh7fff, 16'd0);
        send_sample(-16'sh8000, 16'd65535);
        stop_sending();
        write_rate(18'd8000);
        send_sample(16'sd30000, 16'd4000);
        send_sample(-16'sd30000, 16'd65535);
        stop_sending();
        write_rate(18'd192000);
        send_sample(16'sd15000, 16'(96000 % 65536));
        stop_sending();
    endtask

    task automatic test_random_phase(input logic [APF_RATE_W-1:0] rate,
                                     input int idle, input int stall, input int n);
        write_rate(rate);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) send_sample(rand_sample(), rand_cutoff());
        stop_sending();
        wait_drained();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_rate_extremes();
        test_odd_rates();
        test_random_phase(18'd48000, 0, 0, 180);
        test_random_phase(18'd44100, 83, 0, 170);
        test_random_phase(18'd192000, 0, 83, 170);
        test_random_phase(18'd8000, 26, 26, 170);
        test_random_phase(18'($urandom_range(8000, 192000)), 26, 26, 80);
        test_random_phase(18'($urandom), 0, 0, 80);

        wait_drained();
        mismatch_count += expected_samples.size();
        $display("Sent %0d samples and checked %0d filtered results over %0d cycles.",
                 samples_sent, samples_checked, cycle_count);
        $display("Sample rate was rewritten %0d times, from zero to full scale.",
                 rate_writes);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
